// ===== hdl/dtma_pkg.sv =====
// Shared types and constants for the diode temperature moving-average core.
// No dependencies; used by diode_temperature_moving_average_core and dtma_checker.
package dtma_pkg;

    // Serial divider geometry: 32-bit dividend, divisor below 2**15
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = 5;
    localparam int DVS_W     = 15;
    localparam int REM_W     = DVS_W + 1;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int TEMP_W   = 18;
    localparam int DISP_W   = 19;
    localparam int COUNT_W  = 6;

    // Conversion constants, scaled by 1/100 of the exact form:
    // raw = round(25 * (25657344 - 33000 * sample) / 21504)
    localparam int MV_SCALE    = 3300;
    localparam int RAW_OFFSET  = 25657344;
    localparam int RAW_SLOPE   = 33000;
    localparam int RAW_MULT    = 25;
    localparam int RAW_ROUND   = 10752;
    // 21504 = 2**10 * 21: shift right by 10, then multiply by ceil(2**27 / 21)
    localparam int RAW_PRE_SH  = 10;
    localparam int RAW_RCP     = 6391321;
    localparam int RAW_RCP_SH  = 27;
    localparam int FAH_MULT_SH = 3;
    // Divide by 5: multiply by ceil(2**24 / 5), exact below 2**22
    localparam int FAH_RCP     = 3355444;
    localparam int FAH_RCP_SH  = 24;
    localparam int FAH_ROUND   = 2;
    localparam int FAH_OFFSET  = 3200;
    localparam int THR_RESET   = 4000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_F     = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_RAW_RCP,
        S_DIV,
        S_RAW_DONE,
        S_AVG_LOAD,
        S_AVG_DONE,
        S_FAH_LOAD,
        S_FAH_RCP,
        S_FAH_DONE,
        S_OUT
    } state_t;

endpackage

// ===== hdl/diode_temperature_moving_average_core.sv =====
// Diode temperature front end: conversion, moving-average ring and display scaling.
// Depends on dtma_pkg.
//
// One item is taken at a time. After acceptance the sample goes through conversion, the
// ring update and the divider, plus the scaling states with Fahrenheit display; the block is
// then ready again. The work is dominated by a single 32-step restoring divider that forms
// the average from the running total and the sample count, with load and post-processing
// states around it; the constant divisions of the raw conversion and of the Fahrenheit
// scaling take one reciprocal multiply each. A finished result sits in an output
// register, so the next item may be taken while it waits; the core only holds in its
// last step if the previous result is still untaken. The temperature ring is a
// WINDOW-entry memory with a registered read; it needs no clearing, since entries are
// read only once written.
module diode_temperature_moving_average_core #(
    parameter int WINDOW = 40
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [dtma_pkg::SAMPLE_W-1:0]            adc_sample,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic [11:0]                              voltage_millivolts,
    output logic signed [dtma_pkg::TEMP_W-1:0]       raw_temp_centi,
    output logic signed [dtma_pkg::TEMP_W-1:0]       filtered_temp_centi,
    output logic signed [dtma_pkg::DISP_W-1:0]       display_temp_centi,
    output logic                                     led_on,
    output logic [dtma_pkg::COUNT_W-1:0]             samples_averaged,
    input  logic                                     cfg_write,
    input  logic [dtma_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [dtma_pkg::TEMP_W-1:0]              cfg_data
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = dtma_pkg::TEMP_W + CNT_W;
    localparam int DIV_W  = dtma_pkg::DIV_W;
    localparam int DVS_W  = dtma_pkg::DVS_W;
    localparam int REM_W  = dtma_pkg::REM_W;
    localparam int TW     = dtma_pkg::TEMP_W;
    localparam int DW     = dtma_pkg::DISP_W;

    // Control state
    dtma_pkg::state_t   state_reg, state_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               ring_full_reg, ring_full_next;
    logic signed [SUM_W-1:0] total_reg, total_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [TW-1:0] thr_reg;
    logic               disp_f_reg;

    // Datapath registers
    logic [dtma_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    logic [11:0]        mv_reg, mv_next;
    logic signed [28:0] m_reg, m_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [DVS_W-1:0]   rem_reg, rem_next;
    logic [DVS_W-1:0]   dvs_reg, dvs_next;
    logic [dtma_pkg::DIV_CNT_W-1:0] step_reg, step_next;
    logic               neg_reg, neg_next;
    logic signed [TW-1:0] raw_reg, raw_next;
    logic signed [TW-1:0] avg_reg, avg_next;
    logic signed [DW-1:0] disp_reg, disp_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // Output registers
    logic [11:0]        out_mv_reg, out_mv_next;
    logic signed [TW-1:0] out_raw_reg, out_raw_next;
    logic signed [TW-1:0] out_avg_reg, out_avg_next;
    logic signed [DW-1:0] out_disp_reg, out_disp_next;
    logic               out_led_reg, out_led_next;
    logic [dtma_pkg::COUNT_W-1:0] out_cnt_reg, out_cnt_next;

    // Ring memory
    logic signed [TW-1:0] ring_mem [WINDOW];
    logic signed [TW-1:0] ring_q;
    logic               ring_we;

    // Datapath combinational terms
    logic [23:0]        mv_prod;
    logic [28:0]        slope_prod;
    logic [28:0]        m_neg;
    logic [27:0]        m_mag;
    logic [DIV_W-1:0]   raw_dvd;
    logic [44:0]        raw_rcp_prod;
    logic [42:0]        fah_rcp_prod;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   rem_sub;
    logic               fits;
    logic signed [DIV_W:0] div_res;
    logic signed [TW-1:0] div_temp;
    logic signed [SUM_W-1:0] total_upd;
    logic signed [SUM_W-1:0] total_neg;
    logic [SUM_W-1:0]   total_abs;
    logic signed [21:0] avg_wide;
    logic signed [21:0] avg9;
    logic signed [21:0] avg9_neg;
    logic [21:0]        avg9_abs;
    logic               wrap;
    logic [31:0]        count_wide;
    logic               out_free;

    assign mv_prod    = 24'(sample_reg) * 24'(dtma_pkg::MV_SCALE);
    assign slope_prod = 29'(sample_reg) * 29'(dtma_pkg::RAW_SLOPE);
    assign m_neg      = 29'(-m_reg);
    assign m_mag      = m_reg[28] ? m_neg[27:0] : m_reg[27:0];
    assign raw_dvd    = 32'(m_mag) * 32'(dtma_pkg::RAW_MULT) + 32'(dtma_pkg::RAW_ROUND);

    // Constant divisions by reciprocal multiply on the magnitude held in quo_reg
    assign raw_rcp_prod = 45'(quo_reg[DIV_W-1:dtma_pkg::RAW_PRE_SH])
                          * 45'(dtma_pkg::RAW_RCP);
    assign fah_rcp_prod = 43'(quo_reg[20:0]) * 43'(dtma_pkg::FAH_RCP);

    // Restoring divide step; remainder always stays below the divisor
    assign rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
    assign fits    = (rem_sh >= {1'b0, dvs_reg});
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign div_res = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign div_temp = $signed(div_res[TW-1:0]);

    assign total_upd = total_reg
                       - (ring_full_reg ? SUM_W'(ring_q) : SUM_W'(0))
                       + SUM_W'(div_temp);
    assign total_neg = -total_reg;
    assign total_abs = total_reg[SUM_W-1] ? total_neg : total_reg;

    assign avg_wide = 22'(avg_reg);
    assign avg9     = (avg_wide <<< dtma_pkg::FAH_MULT_SH) + avg_wide;
    assign avg9_neg = -avg9;
    assign avg9_abs = avg9[21] ? avg9_neg : avg9;

    assign wrap       = (slot_reg == SLOT_W'(WINDOW - 1));
    assign count_wide = 32'(count_reg);
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        ring_full_next = ring_full_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        mv_next        = mv_reg;
        m_next         = m_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        step_next      = step_reg;
        neg_next       = neg_reg;
        raw_next       = raw_reg;
        avg_next       = avg_reg;
        disp_next      = disp_reg;
        count_next     = count_reg;
        out_mv_next    = out_mv_reg;
        out_raw_next   = out_raw_reg;
        out_avg_next   = out_avg_reg;
        out_disp_next  = out_disp_reg;
        out_led_next   = out_led_reg;
        out_cnt_next   = out_cnt_reg;
        ring_we        = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            dtma_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = adc_sample;
                    state_next  = dtma_pkg::S_MUL;
                end
            end

            dtma_pkg::S_MUL:
            begin
                mv_next    = mv_prod[23:12];
                m_next     = $signed(29'(dtma_pkg::RAW_OFFSET)) - $signed(slope_prod);
                state_next = dtma_pkg::S_SCALE;
            end

            dtma_pkg::S_SCALE:
            begin
                quo_next   = raw_dvd;
                neg_next   = m_reg[28];
                state_next = dtma_pkg::S_RAW_RCP;
            end

            dtma_pkg::S_RAW_RCP:
            begin
                quo_next   = 32'(raw_rcp_prod >> dtma_pkg::RAW_RCP_SH);
                state_next = dtma_pkg::S_RAW_DONE;
            end

            dtma_pkg::S_DIV:
            begin
                rem_next  = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
                quo_next  = {quo_reg[DIV_W-2:0], fits};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = dtma_pkg::S_AVG_DONE;
                end
            end

            dtma_pkg::S_RAW_DONE:
            begin
                // Oldest entry leaves the total only once the ring has wrapped
                raw_next   = div_temp;
                ring_we    = 1'b1;
                total_next = total_upd;
                slot_next  = wrap ? '0 : slot_reg + 1'b1;
                if (wrap)
                begin
                    ring_full_next = 1'b1;
                end
                count_next = (ring_full_reg || wrap) ? CNT_W'(WINDOW)
                                                     : CNT_W'(slot_reg) + 1'b1;
                state_next = dtma_pkg::S_AVG_LOAD;
            end

            dtma_pkg::S_AVG_LOAD:
            begin
                quo_next   = 32'(total_abs) + 32'(count_reg >> 1);
                rem_next   = '0;
                dvs_next   = DVS_W'(count_reg);
                neg_next   = total_reg[SUM_W-1];
                step_next  = dtma_pkg::DIV_CNT_W'(DIV_W - 1);
                state_next = dtma_pkg::S_DIV;
            end

            dtma_pkg::S_AVG_DONE:
            begin
                avg_next = div_temp;
                if (disp_f_reg)
                begin
                    state_next = dtma_pkg::S_FAH_LOAD;
                end
                else
                begin
                    disp_next  = DW'(div_temp);
                    state_next = dtma_pkg::S_OUT;
                end
            end

            dtma_pkg::S_FAH_LOAD:
            begin
                quo_next   = 32'(avg9_abs) + 32'(dtma_pkg::FAH_ROUND);
                neg_next   = avg9[21];
                state_next = dtma_pkg::S_FAH_RCP;
            end

            dtma_pkg::S_FAH_RCP:
            begin
                quo_next   = 32'(fah_rcp_prod >> dtma_pkg::FAH_RCP_SH);
                state_next = dtma_pkg::S_FAH_DONE;
            end

            dtma_pkg::S_FAH_DONE:
            begin
                disp_next  = $signed(div_res[DW-1:0]) + DW'(dtma_pkg::FAH_OFFSET);
                state_next = dtma_pkg::S_OUT;
            end

            dtma_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_mv_next    = mv_reg;
                    out_raw_next   = raw_reg;
                    out_avg_next   = avg_reg;
                    out_disp_next  = disp_reg;
                    out_led_next   = (avg_reg < thr_reg);
                    out_cnt_next   = count_wide[dtma_pkg::COUNT_W-1:0];
                    state_next     = dtma_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = dtma_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtma_pkg::S_IDLE;
            slot_reg      <= '0;
            ring_full_reg <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            ring_full_reg <= ring_full_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= TW'(dtma_pkg::THR_RESET);
            disp_f_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dtma_pkg::CFG_LED_THRESHOLD: thr_reg    <= $signed(cfg_data);
                dtma_pkg::CFG_DISPLAY_F:     disp_f_reg <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        mv_reg       <= mv_next;
        m_reg        <= m_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        neg_reg      <= neg_next;
        raw_reg      <= raw_next;
        avg_reg      <= avg_next;
        disp_reg     <= disp_next;
        count_reg    <= count_next;
        out_mv_reg   <= out_mv_next;
        out_raw_reg  <= out_raw_next;
        out_avg_reg  <= out_avg_next;
        out_disp_reg <= out_disp_next;
        out_led_reg  <= out_led_next;
        out_cnt_reg  <= out_cnt_next;
    end

    // Ring: one write port, registered read at the current slot
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[slot_reg] <= div_temp;
        end
        ring_q <= ring_mem[slot_reg];
    end

    assign in_stall            = (state_reg != dtma_pkg::S_IDLE);
    assign out_valid           = out_valid_reg;
    assign voltage_millivolts  = out_mv_reg;
    assign raw_temp_centi      = out_raw_reg;
    assign filtered_temp_centi = out_avg_reg;
    assign display_temp_centi  = out_disp_reg;
    assign led_on              = out_led_reg;
    assign samples_averaged    = out_cnt_reg;

endmodule

// ===== hdl/dtma_checker.sv =====
// Port-level assertions for diode_temperature_moving_average_core, and the bind.
// Depends on dtma_pkg and the core's port list.
module dtma_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [11:0]                        voltage_millivolts,
    input logic [dtma_pkg::TEMP_W-1:0]        raw_temp_centi,
    input logic [dtma_pkg::TEMP_W-1:0]        filtered_temp_centi
);

    // An accepted item keeps the core busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("core ready straight after taking an item");

    // A new result only comes out of a busy core
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without work in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(filtered_temp_centi)))
        else $error("stalled result dropped or changed");

    // Conversion stays inside the sensor's range for every sample
    a_conv_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (voltage_millivolts <= 12'd3300)
                      && ($signed(raw_temp_centi) >= -127300)
                      && ($signed(raw_temp_centi) <= 29900))
        else $error("converted value out of range");

endmodule

bind diode_temperature_moving_average_core dtma_checker u_dtma_checker (.*);
